// File: rtl/core/depq_pkg.sv
package depq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HELD_W   = 11;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MAX = 2'd1,
    OP_DEL_MIN = 2'd2,
    OP_REPORT  = 2'd3
  } depq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } depq_status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del_lo;
    logic                    del_hi;
    logic                    clr;
    logic signed [KEY_W-1:0] key;
  } depq_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    v;
    logic                    g_lo;
    logic                    g_hi;
    logic signed [KEY_W-1:0] lo;
    logic signed [KEY_W-1:0] hi;
  } depq_link_t;

endpackage

// File: rtl/core/depq_if.sv
interface depq_op_if import depq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface depq_res_if import depq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [KEY_W-1:0] largest;
  logic signed [KEY_W-1:0] smallest;
  logic [HELD_W-1:0]       held;

  modport source (output valid, output status, output largest, output smallest,
                  output held, input ready);
  modport sink   (input valid, input status, input largest, input smallest,
                  input held, output ready);
endinterface

// File: rtl/core/depq_cell.sv
module depq_cell import depq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  depq_ctrl_t              ctrl_i,
  input  depq_link_t              left_i,
  input  depq_link_t              right_i,
  output depq_link_t              self_o,
  output logic signed [KEY_W-1:0] lo_nxt_o,
  output logic signed [KEY_W-1:0] hi_nxt_o
);

  logic                    v_q, v_d;
  logic signed [KEY_W-1:0] lo_q, lo_d;
  logic signed [KEY_W-1:0] hi_q, hi_d;
  logic                    g_lo, g_hi;

  // empty cells count as beyond the new key in both chains
  assign g_lo = !v_q || (lo_q > ctrl_i.key);
  assign g_hi = !v_q || (hi_q < ctrl_i.key);

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    v_d  = v_q;
    if (ctrl_i.ins) begin
      if (g_lo) begin
        lo_d = left_i.g_lo ? left_i.lo : ctrl_i.key;
      end
      if (g_hi) begin
        hi_d = left_i.g_hi ? left_i.hi : ctrl_i.key;
      end
      v_d = left_i.v;
    end else if (ctrl_i.del_lo || ctrl_i.del_hi) begin
      if (ctrl_i.del_lo) begin
        lo_d = right_i.lo;
      end
      if (ctrl_i.del_hi) begin
        hi_d = right_i.hi;
      end
      v_d = right_i.v;
    end else if (ctrl_i.clr) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign self_o   = '{v: v_q, g_lo: g_lo, g_hi: g_hi, lo: lo_q, hi: hi_q};
  assign lo_nxt_o = lo_d;
  assign hi_nxt_o = hi_d;

endmodule

// File: rtl/core/depq_chain.sv
module depq_chain import depq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  depq_ctrl_t              ctrl_i,
  output logic signed [KEY_W-1:0] lo_head_o,
  output logic signed [KEY_W-1:0] hi_head_o
);

  depq_link_t              link [CAPACITY];
  logic signed [KEY_W-1:0] lo_nxt [CAPACITY];
  logic signed [KEY_W-1:0] hi_nxt [CAPACITY];

  // head of the chain: always filled from the left, never wins a compare
  localparam depq_link_t HEAD_LINK = '{v: 1'b1, g_lo: 1'b0, g_hi: 1'b0,
                                      lo: '0, hi: '0};
  // tail of the chain: nothing valid shifts in
  localparam depq_link_t TAIL_LINK = '{v: 1'b0, g_lo: 1'b1, g_hi: 1'b1,
                                      lo: '0, hi: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    depq_link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = HEAD_LINK;
    end else begin : g_mid_l
      assign left_l = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_l = TAIL_LINK;
    end else begin : g_mid_r
      assign right_l = link[i+1];
    end
    depq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_i),
      .left_i   (left_l),
      .right_i  (right_l),
      .self_o   (link[i]),
      .lo_nxt_o (lo_nxt[i]),
      .hi_nxt_o (hi_nxt[i])
    );
  end

  assign lo_head_o = lo_nxt[0];
  assign hi_head_o = hi_nxt[0];

endmodule

// File: rtl/core/double_ended_priority_queue_top.sv
// double-ended priority queue of signed 32-bit keys, duplicates allowed
//
// op_i channel: one item per operation (op, key); op selects insert,
// delete largest, delete smallest, or report then clear
// res_o channel: exactly one item per accepted operation, in order, with
// status, largest and smallest key and the count held
//
// storage is a row of CAPACITY identical cells; each cell holds one slot of
// an ascending chain (smallest at cell 0) and one slot of a descending chain
// (largest at cell 0) plus a shared valid bit; an insert places the key by a
// compare with the neighbor, a delete shifts one chain down by one cell
//
// timing: the result item is registered and shows in the cycle after the
// operation is accepted; throughput is one item per cycle while res_o does
// not stall; each cell updates with one compare plus a neighbor select
//
// reset: valid bits and the count clear at once, the queue is empty and
// usable as soon as reset is released; key slots need no clearing
// stall: while a result waits on res_o, op_i ready stays low unless the
// receiver takes the result in the same cycle
module double_ended_priority_queue_top import depq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  depq_op_if.sink    op_i,
  depq_res_if.source res_o
);

  logic                    in_fire;
  logic                    full;
  logic [CNT_W-1:0]        count_q, count_d, view_cnt;
  logic                    empty;
  depq_op_e                op;
  depq_ctrl_t              ctrl;
  logic signed [KEY_W-1:0] lo_head, hi_head;

  logic                    out_valid_q;
  depq_status_e            status_q, status_d;
  logic signed [KEY_W-1:0] largest_q, largest_d;
  logic signed [KEY_W-1:0] smallest_q, smallest_d;
  logic [HELD_W-1:0]       held_q, held_d;

  // accept whenever the output register is free or drains this cycle
  assign op_i.ready = !out_valid_q || res_o.ready;
  assign in_fire    = op_i.valid && op_i.ready;
  assign op         = depq_op_e'(op_i.op);
  assign full       = (count_q == CNT_W'(CAPACITY));

  // command to the cell row, only on an accepted item
  always_comb begin
    ctrl        = '0;
    ctrl.key    = op_i.key;
    if (in_fire) begin
      unique case (op)
        OP_INSERT:  ctrl.ins    = !full;
        OP_DEL_MAX: ctrl.del_hi = (count_q != '0);
        OP_DEL_MIN: ctrl.del_lo = (count_q != '0);
        OP_REPORT:  ctrl.clr    = 1'b1;
        default:    ctrl        = '0;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.del_hi || ctrl.del_lo) begin
      count_d = count_q - CNT_W'(1);
    end else if (ctrl.clr) begin
      count_d = '0;
    end
  end

  depq_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .lo_head_o (lo_head),
    .hi_head_o (hi_head)
  );

  // a report describes the contents before its clear; keys are untouched by
  // the clear, so the chain heads are valid either way
  assign view_cnt = (op == OP_REPORT) ? count_q : count_d;
  assign empty    = (view_cnt == '0);

  always_comb begin
    if (op == OP_INSERT && full) begin
      status_d = ST_FULL;
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_OK;
    end
    largest_d  = empty ? '0 : hi_head;
    smallest_d = empty ? '0 : lo_head;
    held_d     = HELD_W'(view_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q   <= status_d;
      largest_q  <= largest_d;
      smallest_q <= smallest_d;
      held_q     <= held_d;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.status   = status_q;
  assign res_o.largest  = largest_q;
  assign res_o.smallest = smallest_q;
  assign res_o.held     = held_q;

endmodule

// File: rtl/core/depq_checker.sv
module depq_checker import depq_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [1:0]              status_i,
  input logic signed [KEY_W-1:0] largest_i,
  input logic signed [KEY_W-1:0] smallest_i,
  input logic [HELD_W-1:0]       held_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(largest_i) && $stable(smallest_i) && $stable(held_i))
    else $error("result changed while stalled");

  // no new item while a result is stuck
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input ready while output stalled");

  // empty status carries zero keys and count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EMPTY |->
      largest_i == '0 && smallest_i == '0 && held_i == '0)
    else $error("empty result with nonzero fields");

  // sorted contents: smallest never above largest
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_OK |-> smallest_i <= largest_i)
    else $error("smallest above largest");

  // dropped insert only at full capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FULL |-> held_i == HELD_W'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind double_ended_priority_queue_top depq_checker u_depq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (op_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .largest_i   (res_o.largest),
  .smallest_i  (res_o.smallest),
  .held_i      (res_o.held)
);

// File: tb/sv/double_ended_priority_queue_checker.sv
module double_ended_priority_queue_checker import depq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  depq_op_if          op_i,
  depq_res_if         res_i,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned full_drops_o,
  output int unsigned empty_views_o,
  output int unsigned fail_count_o
);

  localparam int unsigned MAX_PRINTED = 20;

  typedef struct packed {
    depq_status_e            status;
    logic signed [KEY_W-1:0] largest;
    logic signed [KEY_W-1:0] smallest;
    logic [HELD_W-1:0]       held;
  } queue_view_t;

  // keys held, ascending
  logic signed [KEY_W-1:0] sorted_keys[$];
  queue_view_t             pending_views[$];
  queue_view_t             op_view;
  queue_view_t             want_view;

  int unsigned n_checked;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_fail;

  assign checked_o     = n_checked;
  assign full_drops_o  = n_full;
  assign empty_views_o = n_empty;
  assign fail_count_o  = n_fail;

  task automatic report_failure(string msg);
    n_fail++;
    if (n_fail <= MAX_PRINTED) $display("error: %s", msg);
  endtask

  function automatic queue_view_t apply_operation(depq_op_e op, logic signed [KEY_W-1:0] key);
    queue_view_t view;
    int          pos;
    view.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (sorted_keys.size() >= CAPACITY) begin
          view.status = ST_FULL;
        end else begin
          // equal keys go after the ones already held
          pos = sorted_keys.size();
          while (pos > 0 && sorted_keys[pos-1] > key) pos--;
          sorted_keys.insert(pos, key);
        end
      end
      OP_DEL_MAX: if (sorted_keys.size() != 0) void'(sorted_keys.pop_back());
      OP_DEL_MIN: if (sorted_keys.size() != 0) void'(sorted_keys.pop_front());
      default: ;
    endcase
    if (view.status == ST_OK && sorted_keys.size() == 0) view.status = ST_EMPTY;
    if (sorted_keys.size() == 0) begin
      view.largest  = '0;
      view.smallest = '0;
      view.held     = '0;
    end else begin
      view.largest  = sorted_keys[$];
      view.smallest = sorted_keys[0];
      view.held     = HELD_W'(sorted_keys.size());
    end
    // report shows the contents, then empties the queue
    if (op == OP_REPORT) sorted_keys.delete();
    return view;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_keys.delete();
      pending_views.delete();
      pending_o <= 0;
    end else begin
      if (op_i.valid && op_i.ready) begin
        op_view = apply_operation(depq_op_e'(op_i.op), op_i.key);
        if (op_view.status == ST_FULL) n_full++;
        if (op_view.status == ST_EMPTY) n_empty++;
        pending_views.push_back(op_view);
      end
      if (res_i.valid && res_i.ready) begin
        if (pending_views.size() == 0) begin
          report_failure("result item with no operation pending");
        end else begin
          want_view = pending_views.pop_front();
          if (res_i.status !== want_view.status)
            report_failure($sformatf("result %0d: status %0d, expected %0d",
                                     n_checked, res_i.status, want_view.status));
          if (res_i.largest !== want_view.largest)
            report_failure($sformatf("result %0d: largest %0d, expected %0d",
                                     n_checked, res_i.largest, want_view.largest));
          if (res_i.smallest !== want_view.smallest)
            report_failure($sformatf("result %0d: smallest %0d, expected %0d",
                                     n_checked, res_i.smallest, want_view.smallest));
          if (res_i.held !== want_view.held)
            report_failure($sformatf("result %0d: held %0d, expected %0d",
                                     n_checked, res_i.held, want_view.held));
          n_checked++;
        end
      end
      pending_o <= pending_views.size();
    end
  end

endmodule

// File: tb/sv/double_ended_priority_queue_top_test.sv
module double_ended_priority_queue_top_test;
  import depq_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned ITEM_TARGET  = 1750;
  // chance in a hundred that a side idles in a given cycle
  localparam int unsigned IDLE_PCT     = 34;
  // long receiver hold-off, enough to back the block up into its input
  localparam int unsigned HOLD_CYCLES  = 80;
  // result shows in the cycle after the op is taken; the drain settles everything
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  depq_op_if  op_if ();
  depq_res_if res_if ();

  double_ended_priority_queue_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_if),
    .res_o  (res_if)
  );

  int unsigned pending;
  int unsigned checked;
  int unsigned full_drops;
  int unsigned empty_views;
  int unsigned fail_count;

  double_ended_priority_queue_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_if),
    .res_i         (res_if),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_drops_o  (full_drops),
    .empty_views_o (empty_views),
    .fail_count_o  (fail_count)
  );

  // stimulus bookkeeping
  int unsigned items_sent;
  int unsigned op_tally [4];
  // steady: neither side idles at random; hold_requests: bumped to ask for a hold-off
  bit          steady;
  int unsigned hold_requests;
  int unsigned cycle_count;

  // watchdog, counts every cycle from time zero
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("double_ended_priority_queue_top_test NOT OK");
      $finish;
    end
  end

  // key mix: extremes, a narrow band around zero for duplicates, full range
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return KEY_MAX;
          1:       return KEY_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return KEY_W'($signed($urandom_range(40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  // offer one item and hold it until the block takes it; random idle
  // cycles go in front unless the run is in its steady stretch
  task automatic send_op(depq_op_e op, logic signed [KEY_W-1:0] key);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      op_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_if.valid <= 1'b1;
    op_if.op    <= op;
    op_if.key   <= key;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    items_sent++;
    op_tally[op]++;
  endtask

  // one batch of random ops, mostly inserts and deletes with an
  // occasional stray report, always closed by a report that clears
  task automatic run_batch(int unsigned len, int unsigned insert_pct);
    int unsigned roll;
    repeat (len) begin
      roll = $urandom_range(99);
      if (roll < insert_pct) begin
        send_op(OP_INSERT, pick_key());
      end else if (roll < 97) begin
        if ($urandom_range(1) != 0) send_op(OP_DEL_MAX, $urandom);
        else send_op(OP_DEL_MIN, $urandom);
      end else begin
        send_op(OP_REPORT, $urandom);
      end
    end
    send_op(OP_REPORT, $urandom);
  endtask

  // result side: random stalls, plus a long hold-off whenever asked; the
  // hold-off counts its cycles here while the sender keeps offering
  initial begin
    int unsigned stall_left;
    int unsigned hold_served;
    stall_left  = 0;
    hold_served = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // op side: directed cases, then random batches with one fill to capacity
  initial begin
    int unsigned batch;
    op_if.valid <= 1'b0;
    op_if.op    <= OP_INSERT;
    op_if.key   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // deletes and a report on an empty queue are all flagged empty
    send_op(OP_DEL_MAX, KEY_MAX);
    send_op(OP_DEL_MIN, KEY_MIN);
    send_op(OP_REPORT, '1);
    // both key extremes, zero, minus one, and duplicates of zero and both extremes
    send_op(OP_INSERT, KEY_MAX);
    send_op(OP_INSERT, KEY_MIN);
    send_op(OP_INSERT, '0);
    send_op(OP_INSERT, '1);
    send_op(OP_INSERT, '0);
    send_op(OP_INSERT, KEY_MIN);
    send_op(OP_INSERT, KEY_MAX);
    // trim both ends; the second delete-smallest takes the duplicate minimum
    send_op(OP_DEL_MAX, '0);
    send_op(OP_DEL_MIN, '0);
    send_op(OP_DEL_MIN, KEY_MAX);
    // report a non-empty queue, then confirm it was cleared
    send_op(OP_REPORT, '0);
    send_op(OP_DEL_MIN, '1);
    // an op that leaves the queue empty, from either end
    send_op(OP_INSERT, 32'sd5);
    send_op(OP_DEL_MIN, '0);
    send_op(OP_INSERT, -32'sd7);
    send_op(OP_DEL_MAX, '0);
    // equal keys only, then report
    send_op(OP_INSERT, 32'sd1);
    send_op(OP_INSERT, 32'sd1);
    send_op(OP_REPORT, KEY_MIN);

    batch = 0;
    while (items_sent < ITEM_TARGET) begin
      // every batch starts on an empty queue since each ends in a report
      if (batch == 4) begin
        // long stretch with no random idling: fill to capacity, push past it,
        // free one slot, refill it, drop one more, then trim and report
        steady = 1'b1;
        hold_requests++;
        repeat (CAPACITY + 4) send_op(OP_INSERT, pick_key());
        send_op(OP_DEL_MAX, $urandom);
        send_op(OP_INSERT, pick_key());
        send_op(OP_INSERT, KEY_MIN);
        repeat (3) send_op(OP_DEL_MIN, $urandom);
        send_op(OP_INSERT, KEY_MAX);
        send_op(OP_REPORT, $urandom);
        steady = 1'b0;
      end else begin
        if (batch % 6 == 2) hold_requests++;
        run_batch($urandom_range(8, 64), $urandom_range(35, 80));
      end
      batch++;
    end
    op_if.valid <= 1'b0;

    // first let the pending count take in the last accepted item, then
    // let every expected result arrive and the DRAIN_CYCLES quiet cycles pass
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d ops: %0d inserts, %0d delete-largest, %0d delete-smallest, %0d reports",
             items_sent, op_tally[OP_INSERT], op_tally[OP_DEL_MAX],
             op_tally[OP_DEL_MIN], op_tally[OP_REPORT]);
    $display("checked %0d results: %0d empty, %0d full-store drops, %0d mismatches",
             checked, empty_views, full_drops, fail_count);
    if (fail_count == 0) begin
      $display("double_ended_priority_queue_top_test OK");
    end else begin
      $display("double_ended_priority_queue_top_test NOT OK");
    end
    $finish;
  end

endmodule
